// ===== rtl/midi_cc_pickup_parameter_table_core_macros.svh =====
// Assertion macros shared by the RTL of the controller pickup parameter table.
`ifndef MIDI_CC_PICKUP_PARAMETER_TABLE_CORE_MACROS_SVH
`define MIDI_CC_PICKUP_PARAMETER_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mcpt_pkg.sv =====
// Types, constants and conversion function of the controller pickup parameter table.
`default_nettype none
package mcpt_pkg;

    localparam int BANK_SIZE  = 8;
    localparam int FRAC_BITS  = 14;
    localparam int NUM_SLOTS  = 16;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int VAL_W      = FRAC_BITS + 2;
    localparam int WIDE_W     = VAL_W + 1;
    localparam int THR_W      = FRAC_BITS + 1;
    localparam int CC_W       = 7;
    localparam int BANK_W     = 8;
    localparam int STATUS_W   = 8;
    localparam int CFG_W      = THR_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [STATUS_W-1:0] CC_STATUS     = STATUS_W'(176);
    localparam int                  CC_FULL_SCALE = 127;
    localparam int                  CC_HALF       = CC_FULL_SCALE / 2;

    localparam longint CC_QUOT     = (longint'(1) <<< FRAC_BITS) / CC_FULL_SCALE;
    localparam longint CC_REM      = (longint'(1) <<< FRAC_BITS) % CC_FULL_SCALE;
    localparam int     RECIP_SHIFT = 21;
    localparam longint CC_RECIP    = (longint'(1) <<< RECIP_SHIFT) / CC_FULL_SCALE + 1;

    localparam logic signed [VAL_W-1:0] UNIT_POS = VAL_W'(longint'(1) <<< FRAC_BITS);
    localparam logic signed [VAL_W-1:0] UNIT_NEG = -UNIT_POS;

    localparam logic [THR_W-1:0]  PICKUP_RST = THR_W'(573);
    localparam logic [THR_W-1:0]  DEADZONE_RST = THR_W'(131);
    localparam logic [CC_W-1:0]   BANK0_RST  = CC_W'(16);
    localparam logic [CC_W-1:0]   BANK1_RST  = CC_W'(120);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    typedef enum logic [1:0] {
        REQ_MIDI   = 2'd0,
        REQ_SLIDER = 2'd1,
        REQ_FRAME  = 2'd2,
        REQ_RESET  = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PICKUP   = 2'd0,
        CFG_DEADZONE = 2'd1,
        CFG_BANK0    = 2'd2,
        CFG_BANK1    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CC_LO,
        ST_CC_HI,
        ST_FRAME
    } t_state;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [STATUS_W-1:0]     midi_status;
        logic [CC_W-1:0]         cc_number;
        logic [CC_W-1:0]         cc_value;
        logic [SLOT_W-1:0]       slot;
        logic signed [VAL_W-1:0] slider_value;
        logic                    midi_follow;
    } t_in_beat;

    typedef struct packed {
        logic [SLOT_W-1:0]       out_slot;
        logic signed [VAL_W-1:0] param_value;
        logic                    latched;
        logic                    last;
    } t_out_beat;

    // Maps a raw 7-bit controller value to (2v-127)/127 in fixed point, rounded to nearest.
    // The scaled magnitude splits into a whole quotient part and a small remainder part, and
    // the remainder part is divided by a reciprocal multiplication that is exact for its range.
    function automatic logic signed [VAL_W-1:0] cc_to_fixed(input logic [CC_W-1:0] v);
        longint k;
        longint a;
        longint t;
        longint m;
        k = 2 * longint'(v) - CC_FULL_SCALE;
        a = (k < 0) ? -k : k;
        t = a * CC_REM + CC_HALF;
        m = a * CC_QUOT + ((t * CC_RECIP) >>> RECIP_SHIFT);
        return (k < 0) ? VAL_W'(-m) : VAL_W'(m);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/midi_cc_pickup_parameter_table_core.sv =====
// Top level of the controller pickup parameter table: tables, sequencer and output stage.
//
// A control-change message is accepted and then makes at most one table write per bank, a
// slider write or a reset-all needs only the accept, and a frame update walks the sixteen
// slots one per cycle while the output side does not stall, holding off the input until the
// last slot is emitted. The controller and parameter tables are read synchronously once per
// slot, and the parameter table is written back for each slot that latches. Reset clears the
// tables at once through per-entry valid bits; no clearing pass is needed.
`default_nettype none
`include "midi_cc_pickup_parameter_table_core_macros.svh"
module midi_cc_pickup_parameter_table_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output      logic                             o_in_ready,
    input  wire mcpt_pkg::t_in_beat               i_in,
    output      logic                             o_out_valid,
    input  wire logic                             i_out_ready,
    output      mcpt_pkg::t_out_beat              o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [mcpt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [mcpt_pkg::CFG_W-1:0]       i_cfg_data
);
    import mcpt_pkg::*;

    t_state r_state, n_state;

    logic [THR_W-1:0] r_pickup_thr;
    logic [THR_W-1:0] r_deadzone;
    logic [CC_W-1:0]  r_bank0_base;
    logic [CC_W-1:0]  r_bank1_base;

    logic [CC_W-1:0]         r_cc_num;
    logic signed [VAL_W-1:0] r_cc_q;
    logic                    r_follow;
    logic [SLOT_W-1:0]       r_cal_slot;

    logic [NUM_SLOTS-1:0] r_ctrl_valid;
    logic [NUM_SLOTS-1:0] r_par_valid;
    logic [NUM_SLOTS-1:0] r_latch;

    logic signed [VAL_W-1:0] r_ctrl_mem [NUM_SLOTS];
    logic signed [VAL_W-1:0] r_par_mem  [NUM_SLOTS];
    logic signed [VAL_W-1:0] r_ctrl_q;
    logic signed [VAL_W-1:0] r_par_q;

    logic      r_out_valid;
    t_out_beat r_out;

    logic                    in_fire;
    logic                    can_emit;
    logic                    emit;
    logic [SLOT_W-1:0]       rd_addr;

    logic                    ctrl_we;
    logic [SLOT_W-1:0]       ctrl_waddr;
    logic                    par_we;
    logic [SLOT_W-1:0]       par_waddr;
    logic signed [VAL_W-1:0] par_wdata;

    logic [CC_W-1:0]         bank_base;
    logic [BANK_W-1:0]       bank_offset;
    logic [BANK_W-1:0]       bank_rel;
    logic [BANK_W-1:0]       bank_slot;

    logic signed [VAL_W-1:0]  slider_sat;

    logic signed [VAL_W-1:0]  cur_ctrl;
    logic signed [VAL_W-1:0]  cur_par;
    logic signed [WIDE_W-1:0] diff;
    logic [WIDE_W-1:0]        diff_mag;
    logic [WIDE_W-1:0]        ctrl_mag;
    logic                     new_latch;
    logic signed [VAL_W-1:0]  followed;
    logic signed [VAL_W-1:0]  slot_value;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign can_emit    = !r_out_valid || i_out_ready;
    assign emit        = (r_state == ST_FRAME) && can_emit;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        if (i_in.slider_value > UNIT_POS) begin
            slider_sat = UNIT_POS;
        end else if (i_in.slider_value < UNIT_NEG) begin
            slider_sat = UNIT_NEG;
        end else begin
            slider_sat = i_in.slider_value;
        end
    end

    always_comb begin
        if (r_state == ST_CC_HI) begin
            bank_base   = r_bank1_base;
            bank_offset = BANK_W'(BANK_SIZE);
        end else begin
            bank_base   = r_bank0_base;
            bank_offset = '0;
        end
        bank_rel  = {1'b0, r_cc_num} - {1'b0, bank_base};
        bank_slot = bank_rel + bank_offset;
    end

    assign cur_ctrl  = r_ctrl_valid[r_cal_slot] ? r_ctrl_q : '0;
    assign cur_par   = r_par_valid[r_cal_slot] ? r_par_q : '0;
    assign diff      = WIDE_W'(cur_ctrl) - WIDE_W'(cur_par);
    assign diff_mag  = diff[WIDE_W-1] ? WIDE_W'(-diff) : WIDE_W'(diff);
    assign ctrl_mag  = cur_ctrl[VAL_W-1] ? WIDE_W'(-WIDE_W'(cur_ctrl)) : WIDE_W'(cur_ctrl);
    assign new_latch = r_follow
                       && (r_latch[r_cal_slot] || (diff_mag < WIDE_W'(r_pickup_thr)));
    assign followed  = (ctrl_mag < WIDE_W'(r_deadzone)) ? '0 : cur_ctrl;
    assign slot_value = new_latch ? followed : cur_par;

    always_comb begin
        n_state    = r_state;
        rd_addr    = '0;
        ctrl_we    = 1'b0;
        ctrl_waddr = bank_slot[SLOT_W-1:0];
        par_we     = 1'b0;
        par_waddr  = i_in.slot;
        par_wdata  = slider_sat;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (t_req'(i_in.req_type))
                        REQ_MIDI: begin
                            if (i_in.midi_status == CC_STATUS) begin
                                n_state = ST_CC_LO;
                            end
                        end
                        REQ_SLIDER: begin
                            par_we = 1'b1;
                        end
                        REQ_FRAME: begin
                            n_state = ST_FRAME;
                        end
                        REQ_RESET: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CC_LO, ST_CC_HI: begin
                ctrl_we = (r_cc_num >= bank_base) && (bank_rel < BANK_W'(BANK_SIZE))
                          && (bank_slot < BANK_W'(NUM_SLOTS));
                n_state = (r_state == ST_CC_LO) ? ST_CC_HI : ST_IDLE;
            end
            ST_FRAME: begin
                rd_addr   = r_cal_slot;
                par_waddr = r_cal_slot;
                par_wdata = followed;
                if (emit) begin
                    par_we = new_latch;
                    if (r_cal_slot == LAST_SLOT) begin
                        n_state = ST_IDLE;
                    end else begin
                        rd_addr = r_cal_slot + SLOT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl_we) begin
            r_ctrl_mem[ctrl_waddr] <= r_cc_q;
        end
        r_ctrl_q <= r_ctrl_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (par_we) begin
            r_par_mem[par_waddr] <= par_wdata;
        end
        r_par_q <= r_par_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pickup_thr <= PICKUP_RST;
            r_deadzone   <= DEADZONE_RST;
            r_bank0_base <= BANK0_RST;
            r_bank1_base <= BANK1_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PICKUP:   r_pickup_thr <= i_cfg_data[THR_W-1:0];
                CFG_DEADZONE: r_deadzone   <= i_cfg_data[THR_W-1:0];
                CFG_BANK0:    r_bank0_base <= i_cfg_data[CC_W-1:0];
                CFG_BANK1:    r_bank1_base <= i_cfg_data[CC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cc_num <= i_in.cc_number;
            r_cc_q   <= cc_to_fixed(i_in.cc_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_valid <= '0;
            r_par_valid  <= '0;
            r_latch      <= '0;
            r_follow     <= 1'b0;
            r_cal_slot   <= '0;
        end else begin
            if (ctrl_we) begin
                r_ctrl_valid[ctrl_waddr] <= 1'b1;
            end
            if (par_we) begin
                r_par_valid[par_waddr] <= 1'b1;
            end
            if (in_fire && (i_in.req_type == REQ_RESET)) begin
                r_par_valid <= '0;
                r_latch     <= '0;
            end
            if (in_fire && (i_in.req_type == REQ_FRAME)) begin
                r_follow   <= i_in.midi_follow;
                r_cal_slot <= '0;
                if (!i_in.midi_follow) begin
                    r_latch <= '0;
                end
            end
            if (emit) begin
                r_latch[r_cal_slot] <= new_latch;
                r_cal_slot          <= r_cal_slot + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.out_slot    <= r_cal_slot;
            r_out.param_value <= slot_value;
            r_out.latched     <= new_latch;
            r_out.last        <= (r_cal_slot == LAST_SLOT);
        end
    end

    `MCPT_ASSERT_NXT(a_frame_start, i_clk, i_rst_n,
        in_fire && (i_in.req_type == REQ_FRAME),
        (r_state == ST_FRAME) && (r_cal_slot == '0), "frame did not start at slot zero")
    `MCPT_ASSERT_NXT(a_frame_end, i_clk, i_rst_n,
        emit && (r_cal_slot == LAST_SLOT), r_state == ST_IDLE, "frame did not end after last slot")
    `MCPT_ASSERT_NXT(a_release, i_clk, i_rst_n,
        in_fire && (i_in.req_type == REQ_FRAME) && !i_in.midi_follow,
        r_latch == '0, "latches not released by a frame without follow")
    `MCPT_ASSERT_IMP(a_last_slot, i_clk, i_rst_n,
        o_out_valid && o_out.last, o_out.out_slot == LAST_SLOT, "last flag on wrong slot")
    `MCPT_ASSERT_IMP(a_no_write_unlatched, i_clk, i_rst_n,
        (r_state == ST_FRAME) && !r_follow, !par_we, "parameter written without follow")

endmodule
`default_nettype wire
